// ===== design/arq_pkg.sv =====
// Shared types and constants of the ARQ receive reorder window.
package arq_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
    localparam int SEQ_BITS     = 6;
    localparam int HDR_SEQ_BITS = 6;
    localparam int PAYLOAD_BITS = 64;
    localparam int HDR_BITS     = 8;
    localparam int WORD_BITS    = 64;
    localparam int ACK_BITS     = 24;
    localparam int MAX_DELIVER  = 15;

    typedef logic [SEQ_BITS-1:0]            seq_t;
    typedef logic [SLOT_BITS-1:0]           slot_t;
    typedef logic [WINDOW_DEPTH-1:0]        mark_map_t;
    typedef logic [$clog2(MAX_DELIVER)-1:0] cnt_t;
    typedef logic [1:0]                     status_t;
    typedef logic [1:0]                     frame_type_t;

    localparam status_t ST_NORMAL   = 2'd1;
    localparam status_t ST_RESET    = 2'd2;
    localparam status_t ST_SYNC_ERR = 2'd3;

    localparam frame_type_t TYPE_DATA  = 2'b01;
    localparam frame_type_t TYPE_RESET = 2'b10;

    typedef struct packed {
        seq_t                    tag;
        logic [PAYLOAD_BITS-1:0] data;
    } entry_t;

endpackage

// ===== design/arq_if.sv =====
// Valid/ready channel interfaces for frame input and result output beats.
interface arq_in_if;
    import arq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [HDR_BITS-1:0]  header;
    logic [WORD_BITS-1:0] payload;

    modport source (output valid, kind, header, payload, input ready);
    modport sink (input valid, kind, header, payload, output ready);
endinterface

interface arq_out_if;
    import arq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind_out;
    logic [WORD_BITS-1:0] payload_out;
    logic [ACK_BITS-1:0]  ack_report;
    logic                 last;

    modport source (output valid, kind_out, payload_out, ack_report, last, input ready);
    modport sink (input valid, kind_out, payload_out, ack_report, last, output ready);
endinterface

// ===== design/arq_receive_reorder_window.sv =====
// Selective-repeat ARQ receiver: reorder buffer memory and in-order delivery.
// Report: a request beat moves idle to ack, which loads the output stage. A
// frame that extends the run moves idle through read to data, which delivers
// one payload a cycle while the output stage has room. Beats are taken in idle
// only; a run drains up to 15 slots through the memory's single read port.
// Reset: rst_n clears the window, status goes to reset state; no clearing pass.
module arq_receive_reorder_window (
    input  logic        clk,
    input  logic        rst_n,
    arq_in_if.sink      frame,
    arq_out_if.source   result
);
    import arq_pkg::*;

    // Idle takes beats; ack loads a report; read primes the memory port;
    // data delivers one payload a cycle while the output stage has room.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ACK,
        S_READ,
        S_DATA
    } state_t;

    state_t    state_reg, state_next;
    seq_t      lio_reg, lio_next;          // last in-order sequence
    mark_map_t bitmap_reg, bitmap_next;    // bit 15 is one ahead
    status_t   status_reg, status_next;
    logic      sync_err_reg, sync_err_next;
    cnt_t      cnt_reg, cnt_next;          // payloads delivered for this frame

    // Output stage: holds a finished beat until the sink takes it
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [WORD_BITS-1:0] out_payload_reg, out_payload_next;
    logic [ACK_BITS-1:0]  out_ack_reg, out_ack_next;
    logic                 out_last_reg, out_last_next;

    // Reorder buffer: payload and sequence tag per slot
    entry_t mem [WINDOW_DEPTH];
    entry_t rd_data_reg;
    slot_t  rd_addr;

    logic        in_fire;
    frame_type_t ftype;
    seq_t        seq_in;
    seq_t        ahead;
    logic        in_window;
    slot_t       bit_idx;
    mark_map_t   bitmap_set;
    logic        wr_en;
    logic        out_free;
    seq_t        next_seq;
    logic        tag_ok;
    logic        done_now;

    assign in_fire   = frame.valid && frame.ready;
    assign ftype     = frame.header[HDR_BITS-1 -: 2];
    assign seq_in    = SEQ_BITS'(frame.header[HDR_SEQ_BITS-1:0]);
    assign ahead     = seq_in - lio_reg;
    assign in_window = (ahead != '0) && (ahead <= seq_t'(WINDOW_DEPTH));
    // One ahead maps to bit 15, a full window ahead to bit 0
    assign bit_idx    = slot_t'(seq_t'(WINDOW_DEPTH) - ahead);
    assign bitmap_set = bitmap_reg | (mark_map_t'(1) << bit_idx);

    assign wr_en = in_fire && !frame.kind && (ftype == TYPE_DATA)
                   && !sync_err_reg && in_window;

    assign out_free = !out_valid_reg || result.ready;
    assign next_seq = lio_reg + seq_t'(1);
    assign tag_ok   = (rd_data_reg.tag == next_seq);
    // Final delivery when the run breaks or the per-frame limit is reached
    assign done_now = !bitmap_reg[WINDOW_DEPTH-2] || (cnt_reg == cnt_t'(MAX_DELIVER - 1));

    // Read the slot of the next in-order sequence; advance one ahead
    // whenever a payload leaves so the port streams one slot a cycle.
    always_comb
    begin
        if (state_reg == S_DATA && out_free)
        begin
            rd_addr = slot_t'(next_seq + seq_t'(1));
        end
        else
        begin
            rd_addr = slot_t'(next_seq);
        end
    end

    // Writes happen only on an accepted beat in idle; a read then may return the old
    // entry of the slot being written, and the read state reads the slot again.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_t'(seq_in)] <= '{tag: seq_in, data: frame.payload[PAYLOAD_BITS-1:0]};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        lio_next         = lio_reg;
        bitmap_next      = bitmap_reg;
        status_next      = status_reg;
        sync_err_next    = sync_err_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_payload_next = out_payload_reg;
        out_ack_next     = out_ack_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (frame.kind)
                    begin
                        state_next = S_ACK;
                    end
                    else
                    begin
                        case (ftype)
                            TYPE_DATA:
                            begin
                                if (sync_err_reg)
                                begin
                                    // Drop data until a reset command
                                    status_next = ST_SYNC_ERR;
                                end
                                else if (in_window)
                                begin
                                    bitmap_next = bitmap_set;
                                    cnt_next    = '0;
                                    if (bitmap_set[WINDOW_DEPTH-1])
                                    begin
                                        state_next = S_READ;
                                    end
                                    else
                                    begin
                                        status_next = ST_NORMAL;
                                    end
                                end
                                else
                                begin
                                    // Old or out-of-window sequence: drop
                                    status_next = ST_NORMAL;
                                end
                            end
                            TYPE_RESET:
                            begin
                                lio_next      = '0;
                                bitmap_next   = '0;
                                sync_err_next = 1'b0;
                                status_next   = ST_RESET;
                            end
                            default:
                            begin
                                // Reserved type: ignore the frame
                            end
                        endcase
                    end
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = 1'b1;
                    out_payload_next = '0;
                    out_ack_next     = {status_reg, HDR_SEQ_BITS'(lio_reg), bitmap_reg};
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = 1'b0;
                    out_payload_next = WORD_BITS'(rd_data_reg.data);
                    out_ack_next     = '0;
                    out_last_next    = done_now;
                    lio_next         = next_seq;
                    bitmap_next      = bitmap_reg << 1;
                    cnt_next         = cnt_reg + cnt_t'(1);
                    if (!tag_ok)
                    begin
                        // Deliver anyway, latch the error
                        sync_err_next = 1'b1;
                    end
                    if (done_now)
                    begin
                        state_next  = S_IDLE;
                        status_next = (sync_err_reg || !tag_ok) ? ST_SYNC_ERR : ST_NORMAL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lio_reg       <= '0;
            bitmap_reg    <= '0;
            status_reg    <= ST_RESET;
            sync_err_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lio_reg       <= lio_next;
            bitmap_reg    <= bitmap_next;
            status_reg    <= status_next;
            sync_err_reg  <= sync_err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output stage: no reset needed
    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_payload_reg <= out_payload_next;
        out_ack_reg     <= out_ack_next;
        out_last_reg    <= out_last_next;
    end

    assign frame.ready        = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.kind_out    = out_kind_reg;
    assign result.payload_out = out_payload_reg;
    assign result.ack_report  = out_ack_reg;
    assign result.last        = out_last_reg;

endmodule

// ===== design/arq_chk.sv =====
// Port-level checker for the ARQ receive reorder window, with its bind.
module arq_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        frame_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        kind_out,
    input logic [63:0] payload_out,
    input logic [23:0] ack_report,
    input logic        last
);
    // A waiting beat stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat withdrawn before it was taken");

    // More results pending: no new input beat may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> !frame_ready)
        else $error("input taken while a delivery run is unfinished");

    // A report is a single, final beat with an empty payload and a live status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind_out |-> last && (payload_out == 64'd0)
                                     && (ack_report[23:22] != 2'd0))
        else $error("malformed acknowledgement report");

    // A delivery carries no report bits
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !kind_out |-> (ack_report == 24'd0))
        else $error("delivery beat carries report bits");
endmodule

bind arq_receive_reorder_window arq_chk u_arq_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .kind_out     (result.kind_out),
    .payload_out  (result.payload_out),
    .ack_report   (result.ack_report),
    .last         (result.last)
);
